>>> design/lks_pkg.sv
package lks_pkg;

	localparam int unsigned NUM_CH     = 4;
	localparam int unsigned CH_W       = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_REPLY  = 3'd1,
		CMD_TEMP   = 3'd2,
		CMD_PARAMS = 3'd3,
		CMD_VERIFY = 3'd4,
		CMD_END    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_INIT    = 2'd0,
		MODE_STANDBY = 2'd1,
		MODE_TREAT   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REQ_NONE      = 2'd0,
		REQ_KEEPALIVE = 2'd1,
		REQ_PARAMS    = 2'd2,
		REQ_TEMP      = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RETRY_LIMIT      = 2'd0,
		CFG_STANDBY_PERIOD   = 2'd1,
		CFG_TREATMENT_PERIOD = 2'd2,
		CFG_INFO_DELAY       = 2'd3
	} cfg_idx_t;

	localparam logic [7:0]  RETRY_LIMIT_RST      = 8'd3;
	localparam logic [15:0] STANDBY_PERIOD_RST   = 16'd1000;
	localparam logic [15:0] TREATMENT_PERIOD_RST = 16'd1000;
	localparam logic [15:0] INFO_DELAY_RST       = 16'd5000;

	typedef struct packed {
		logic [2:0]      command;
		logic [CH_W-1:0] channel;
		logic [7:0]      r_whole;
		logic [7:0]      r_frac;
		logic [7:0]      l_whole;
		logic [7:0]      l_frac;
		logic [7:0]      ilim_whole;
		logic [7:0]      ilim_frac;
		logic [7:0]      tmax_whole;
		logic [7:0]      tmax_frac;
		logic [7:0]      temp_int;
	} evt_t;

	typedef struct packed {
		logic [7:0] channel_requests;
		logic       send_info;
		logic [3:0] info_mask;
		logic       verify_ok;
		logic       link_up;
		logic [7:0] channel_temp;
		logic [1:0] mode;
	} res_t;

	typedef struct packed {
		logic [7:0]  retry_limit;
		logic [15:0] standby_period;
		logic [15:0] treatment_period;
		logic [15:0] info_delay;
	} cfg_t;

	// Shared per-beat controls broadcast to every channel slice.
	typedef struct packed {
		logic       step;
		logic [2:0] command;
		logic       poll;
		logic       treat;
		logic       params_ok;
		logic [7:0] temp;
		logic [7:0] retry_limit;
	} chan_ctl_t;

	// Channel status; live and temp are the values after the current beat.
	typedef struct packed {
		req_t       req;
		logic       verify_ok;
		logic       live;
		logic       locked;
		logic [7:0] temp;
	} chan_sts_t;

endpackage

>>> design/lks_if.sv
interface lks_evt_if;
	logic          valid;
	logic          ready;
	lks_pkg::evt_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lks_res_if;
	logic          valid;
	logic          ready;
	lks_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/four_channel_link_keepalive_supervisor_core.sv
// Link keepalive supervisor for four probe channels.
// Event beats enter on evt (tick, reply, temperature report, parameter report,
// verify, end treatment) and each one produces exactly one result beat on res:
// the per-channel poll requests, the one-time info pulse, the link mask, the
// verify result, the addressed channel's link state and temperature, and the
// mode after the event.
// Timing: a beat is registered at the input, its whole effect on the channel
// state, the timers and the mode is computed from the input register, and the
// result is registered; res presents the output register. One beat per cycle is
// sustained while res is not stalled; the decode and per-channel update logic
// lies between the two registers.
// When res is stalled, the result register holds and the input register fills;
// evt.ready drops only when both stages hold beats.
// Configuration writes (retry limit, poll periods, info delay) go through the
// plain write port and take effect from the next processed beat.
// Reset clears the mode to init, both timers, the info flag and all channel
// state, and restores the register defaults; no beat is held afterward.
module four_channel_link_keepalive_supervisor_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lks_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lks_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lks_evt_if.sink                        evt,
	lks_res_if.source                      res
);
	import lks_pkg::*;

	cfg_t       cfg;
	evt_t       evt_s1;
	logic       vld_s1;
	res_t       res_s2, res_d;
	logic       vld_s2;
	logic       advance, fire;

	mode_t      mode_q, mode_d;
	logic [15:0] poll_timer_q, poll_timer_d, poll_dec;
	logic [15:0] info_timer_q, info_timer_d, info_dec;
	logic       info_done_q, info_done_d;
	logic       send_info;

	chan_ctl_t  ctl;
	chan_sts_t  sts [NUM_CH];
	logic [NUM_CH-1:0] lock_vec, live_vec;
	logic [7:0] req_vec;

	lks_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance   = !vld_s2 || res.ready;
	assign evt.ready = !vld_s1 || advance;
	assign fire      = vld_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (evt.ready) vld_s1 <= evt.valid;
			if (advance)   vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) evt_s1 <= evt.data;
		if (fire)                   res_s2 <= res_d;
	end

	// Timers count down first and hold at zero; the mode machine sees the
	// decremented values.
	assign poll_dec = (poll_timer_q != 16'd0) ? poll_timer_q - 16'd1 : 16'd0;
	assign info_dec = (info_timer_q != 16'd0) ? info_timer_q - 16'd1 : 16'd0;

	always_comb begin
		mode_d       = mode_q;
		poll_timer_d = poll_timer_q;
		info_timer_d = info_timer_q;
		info_done_d  = info_done_q;
		if (evt_s1.command == CMD_TICK) begin
			poll_timer_d = poll_dec;
			info_timer_d = info_dec;
			unique case (mode_q)
				MODE_INIT: begin
					info_timer_d = cfg.info_delay;
					info_done_d  = 1'b0;
					mode_d       = MODE_STANDBY;
				end
				MODE_STANDBY: begin
					if (poll_dec == 16'd0) poll_timer_d = cfg.standby_period;
					if (&lock_vec) mode_d = MODE_TREAT;
					if (info_dec == 16'd0 && !info_done_q) info_done_d = 1'b1;
				end
				MODE_TREAT: begin
					if (poll_dec == 16'd0) poll_timer_d = cfg.treatment_period;
					if (lock_vec == '0) mode_d = MODE_STANDBY;
				end
				default: mode_d = MODE_INIT;
			endcase
		end
	end

	assign send_info = (evt_s1.command == CMD_TICK) && (mode_q == MODE_STANDBY) &&
		(info_dec == 16'd0) && !info_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_INIT;
			poll_timer_q <= 16'd0;
			info_timer_q <= 16'd0;
			info_done_q  <= 1'b0;
		end else if (fire) begin
			mode_q       <= mode_d;
			poll_timer_q <= poll_timer_d;
			info_timer_q <= info_timer_d;
			info_done_q  <= info_done_d;
		end
	end

	assign ctl.step        = fire;
	assign ctl.command     = evt_s1.command;
	assign ctl.poll        = (evt_s1.command == CMD_TICK) && (poll_dec == 16'd0) &&
		(mode_q == MODE_STANDBY || mode_q == MODE_TREAT);
	assign ctl.treat       = (mode_q == MODE_TREAT);
	assign ctl.params_ok   =
		((evt_s1.r_whole | evt_s1.r_frac) != 8'd0) &&
		((evt_s1.l_whole | evt_s1.l_frac) != 8'd0) &&
		((evt_s1.ilim_whole | evt_s1.ilim_frac) != 8'd0) &&
		((evt_s1.tmax_whole | evt_s1.tmax_frac) != 8'd0);
	assign ctl.temp        = evt_s1.temp_int;
	assign ctl.retry_limit = cfg.retry_limit;

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
		lks_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (evt_s1.channel == CH_W'(c)),
			.sts    (sts[c])
		);
		assign lock_vec[c]         = sts[c].locked;
		assign live_vec[c]         = sts[c].live;
		assign req_vec[2*c +: 2]   = sts[c].req;
	end

	assign res_d.channel_requests = req_vec;
	assign res_d.send_info        = send_info;
	assign res_d.info_mask        = live_vec;
	assign res_d.verify_ok        = sts[evt_s1.channel].verify_ok;
	assign res_d.link_up          = live_vec[evt_s1.channel];
	assign res_d.channel_temp     = sts[evt_s1.channel].temp;
	assign res_d.mode             = mode_d;

	assign res.valid = vld_s2;
	assign res.data  = res_s2;

	a_info_once: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.send_info) |-> info_done_q)
		else $error("info pulse delivered without the info flag set");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> (vld_s1 && vld_s2 && !res.ready))
		else $error("input stalled while the pipeline has room");

	a_timer_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && evt_s1.command != CMD_TICK) |=> $stable(poll_timer_q))
		else $error("poll timer moved on a beat that is not a tick");

	a_req_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && evt_s1.command != CMD_TICK) |=> (res_s2.channel_requests == 8'd0))
		else $error("channel request raised by a beat that is not a tick");
endmodule

>>> design/lks_cfg.sv
module lks_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lks_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [lks_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output lks_pkg::cfg_t                   cfg
);
	import lks_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit      <= RETRY_LIMIT_RST;
			cfg_q.standby_period   <= STANDBY_PERIOD_RST;
			cfg_q.treatment_period <= TREATMENT_PERIOD_RST;
			cfg_q.info_delay       <= INFO_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_RETRY_LIMIT:      cfg_q.retry_limit      <= cfg_wdata[7:0];
				CFG_STANDBY_PERIOD:   cfg_q.standby_period   <= cfg_wdata;
				CFG_TREATMENT_PERIOD: cfg_q.treatment_period <= cfg_wdata;
				CFG_INFO_DELAY:       cfg_q.info_delay       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> design/lks_chan.sv
module lks_chan (
	input  logic               clk,
	input  logic               arst_n,
	input  lks_pkg::chan_ctl_t ctl,
	input  logic               sel,
	output lks_pkg::chan_sts_t sts
);
	import lks_pkg::*;

	logic       have_q, have_d;
	logic       ans_q, ans_d;
	logic [7:0] ret_q, ret_d;
	logic       lock_q, lock_d;
	logic [7:0] temp_q, temp_d;
	req_t       req;
	logic       vok;

	always_comb begin
		have_d = have_q;
		ans_d  = ans_q;
		ret_d  = ret_q;
		lock_d = lock_q;
		temp_d = temp_q;
		req    = REQ_NONE;
		vok    = 1'b0;
		case (ctl.command)
			CMD_TICK: begin
				if (ctl.poll) begin
					if (!have_q) begin
						req = ctl.treat ? REQ_NONE : REQ_PARAMS;
					end else if (ans_q) begin
						ret_d = ctl.retry_limit;
						ans_d = 1'b0;
						req   = ctl.treat ? REQ_TEMP : REQ_KEEPALIVE;
					end else if (ret_q != 8'd0) begin
						ret_d = ret_q - 8'd1;
						req   = ctl.treat ? REQ_TEMP : REQ_KEEPALIVE;
					end else begin
						// Silent with no retries left: the link is dropped.
						have_d = 1'b0;
					end
				end
			end
			CMD_REPLY: begin
				if (sel) ans_d = 1'b1;
			end
			CMD_TEMP: begin
				if (sel) begin
					temp_d = ctl.temp;
					ans_d  = 1'b1;
				end
			end
			CMD_PARAMS: begin
				if (sel && ctl.params_ok) begin
					have_d = 1'b1;
					ans_d  = 1'b1;
				end
			end
			CMD_VERIFY: begin
				if (sel) begin
					lock_d = 1'b1;
					if (have_q) begin
						ret_d = ctl.retry_limit;
						vok   = 1'b1;
					end
				end
			end
			CMD_END: begin
				if (sel) lock_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			ans_q  <= 1'b0;
			ret_q  <= 8'd0;
			lock_q <= 1'b0;
			temp_q <= 8'd0;
		end else if (ctl.step) begin
			have_q <= have_d;
			ans_q  <= ans_d;
			ret_q  <= ret_d;
			lock_q <= lock_d;
			temp_q <= temp_d;
		end
	end

	assign sts.req       = req;
	assign sts.verify_ok = vok;
	assign sts.live      = have_d && (ret_d != 8'd0);
	assign sts.locked    = lock_q;
	assign sts.temp      = temp_d;
endmodule
